FILE: design/imablk_pkg.sv
// Package for the blocked IMA ADPCM decoder: command and result types, tables and constants.
`default_nettype none

package imablk_pkg;

  localparam int BYTES_PER_CHANNEL_BLOCK = 36;
  localparam int FRAMES_PER_BLOCK        = 64;
  localparam int HEADER_BYTES            = 4;

  localparam logic [6:0]         MAX_STEP_POS = 7'd88;
  localparam logic signed [17:0] PCM_MAX      = 18'sd32767;
  localparam logic signed [17:0] PCM_MIN      = -18'sd32768;
  localparam logic [5:0]         LAST_FRAME   = 6'(FRAMES_PER_BLOCK - 1);

  // Header byte positions within a channel header.
  localparam logic [1:0] HDR_SEED_LO = 2'd0;
  localparam logic [1:0] HDR_SEED_HI = 2'd1;
  localparam logic [1:0] HDR_STEP    = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SEED,
    OP_STEP,
    OP_CODE
  } op_t;

  // One classified byte, handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic        ch;
    logic [15:0] value;
    logic [5:0]  frame;
    logic        two;
    logic        err;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               valid;
    logic               ch;
    logic [5:0]         frame;
    logic               err;
    logic               last;
  } res_t;

  function automatic logic [14:0] step_size(input logic [6:0] pos);
    logic [14:0] s;
    case (pos)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;       7'd3: s = 15'd10;
      7'd4: s = 15'd11;      7'd5: s = 15'd12;      7'd6: s = 15'd13;      7'd7: s = 15'd14;
      7'd8: s = 15'd16;      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;     7'd15: s = 15'd31;
      7'd16: s = 15'd34;     7'd17: s = 15'd37;     7'd18: s = 15'd41;     7'd19: s = 15'd45;
      7'd20: s = 15'd50;     7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;     7'd27: s = 15'd97;
      7'd28: s = 15'd107;    7'd29: s = 15'd118;    7'd30: s = 15'd130;    7'd31: s = 15'd143;
      7'd32: s = 15'd157;    7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;    7'd39: s = 15'd307;
      7'd40: s = 15'd337;    7'd41: s = 15'd371;    7'd42: s = 15'd408;    7'd43: s = 15'd449;
      7'd44: s = 15'd494;    7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;    7'd51: s = 15'd963;
      7'd52: s = 15'd1060;   7'd53: s = 15'd1166;   7'd54: s = 15'd1282;   7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;   7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;   7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;   7'd65: s = 15'd3660;   7'd66: s = 15'd4026;   7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;   7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;   7'd75: s = 15'd9493;
      7'd76: s = 15'd10442;  7'd77: s = 15'd11487;  7'd78: s = 15'd12635;  7'd79: s = 15'd13899;
      7'd80: s = 15'd15289;  7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;  7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step index adjustment: -1 for small codes, 2/4/6/8 for the large ones.
  function automatic logic signed [4:0] step_adjust(input logic [2:0] code);
    logic signed [4:0] a;
    if (code[2]) begin
      a = $signed({2'b00, code[1:0], 1'b0}) + 5'sd2;
    end else begin
      a = -5'sd1;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/ima_adpcm_block_decoder_core.sv
// Top level of the blocked 4-bit IMA ADPCM decoder: front, command queue, back, result queue.
//
//   Channel   Ports                                           Transaction when
//   input     push, full, data_byte, stream_end               push && !full
//   result    empty, pop, pcm_sample, sample_valid,           pop && !empty
//             sample_channel, frame_in_block, length_error,
//             last_of_run
//   config    cfg_we, cfg_data (channel_count)                cfg_we
//
// The back end decodes a code byte one nibble at a time, since each nibble's
// predictor and step index update feeds the next; a block's last code byte yields one sample.
// A byte waits in the command queue and its results in the result queue before the ports.
// Reset (rst, synchronous) empties both queues, zeroes predictors and positions, and
// sets channel_count to mono. full rises when the command queue fills; the back end
// holds while the result queue is full.
`default_nettype none

module ima_adpcm_block_decoder_core #(
  parameter int CMD_DEPTH    = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [7:0]         data_byte,
  input  wire                stream_end,
  output logic               empty,
  input  wire                pop,
  output logic signed [15:0] pcm_sample,
  output logic               sample_valid,
  output logic               sample_channel,
  output logic [5:0]         frame_in_block,
  output logic               length_error,
  output logic               last_of_run,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_data
);

  imablk_pkg::cmd_t cmd_in;
  imablk_pkg::cmd_t cmd_head;
  logic             cmd_write;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;

  imablk_pkg::res_t res_in;
  imablk_pkg::res_t res_head;
  logic             res_push;
  logic             res_full;

  imablk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd_full   (cmd_full),
    .cmd_write  (cmd_write),
    .cmd        (cmd_in)
  );

  imablk_fifo #(
    .DEPTH  (CMD_DEPTH),
    .DATA_T (imablk_pkg::cmd_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_write),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  imablk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  imablk_fifo #(
    .DEPTH  (RESULT_DEPTH),
    .DATA_T (imablk_pkg::res_t)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign full           = cmd_full;
  assign pcm_sample     = res_head.pcm;
  assign sample_valid   = res_head.valid;
  assign sample_channel = res_head.ch;
  assign frame_in_block = res_head.frame;
  assign length_error   = res_head.err;
  assign last_of_run    = res_head.last;

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_pop_only_when_head: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty && !res_full)
    else $error("command retired without a head or without result room");

  a_error_format: assert property (@(posedge clk) disable iff (rst)
    (!empty && length_error) |-> (!sample_valid && last_of_run && pcm_sample == 16'sd0))
    else $error("error transaction carries sample data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire

FILE: design/imablk_fifo.sv
// Small first-word-fall-through queue used between the front, the back and the result port.
`default_nettype none

module imablk_fifo #(
  parameter int  DEPTH  = 4,
  parameter type DATA_T = logic
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        wr_en,
  input  wire DATA_T wr_data,
  input  wire        rd_en,
  output DATA_T      rd_data,
  output logic       full,
  output logic       empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  DATA_T         entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/imablk_front.sv
// Front end: tracks the byte position in the block and classifies each byte into a command.
`default_nettype none

module imablk_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire  [7:0]          data_byte,
  input  wire                 stream_end,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_data,
  input  wire                 cmd_full,
  output logic                cmd_write,
  output imablk_pkg::cmd_t    cmd
);

  localparam logic [7:0] BLOCK_MONO   = 8'(imablk_pkg::BYTES_PER_CHANNEL_BLOCK);
  localparam logic [7:0] BLOCK_STEREO = 8'(2 * imablk_pkg::BYTES_PER_CHANNEL_BLOCK);
  localparam logic [6:0] HDR_MONO     = 7'(imablk_pkg::HEADER_BYTES);
  localparam logic [6:0] HDR_STEREO   = 7'(2 * imablk_pkg::HEADER_BYTES);

  logic [1:0] channel_count;
  logic [6:0] byte_in_block;
  logic [6:0] byte_in_block_next;
  logic [7:0] seed_low_byte;

  logic       stereo;
  logic [7:0] block_len;
  logic [6:0] hdr_len;
  logic [6:0] pos;
  logic [7:0] pos_inc;
  logic       in_header;
  logic [6:0] d;
  logic [2:0] chunk;
  logic       code_ch;
  logic [5:0] frame;

  assign stereo    = (channel_count >= 2'd2);
  assign block_len = stereo ? BLOCK_STEREO : BLOCK_MONO;
  assign hdr_len   = stereo ? HDR_STEREO : HDR_MONO;

  // A position left past the block end by a channel count change starts a new block.
  assign pos       = ({1'b0, byte_in_block} >= block_len) ? 7'd0 : byte_in_block;
  assign pos_inc   = {1'b0, pos} + 8'd1;
  assign in_header = (pos < hdr_len);
  assign d         = pos - hdr_len;
  assign chunk     = stereo ? d[5:3] : d[4:2];
  assign code_ch   = stereo ? d[2] : 1'b0;
  assign frame     = {chunk, d[1:0], 1'b1};

  assign cmd_write = push && !cmd_full;

  always_comb begin
    cmd.op    = imablk_pkg::OP_NONE;
    cmd.ch    = in_header ? pos[2] : code_ch;
    cmd.value = {8'd0, data_byte};
    cmd.frame = frame;
    cmd.two   = (frame != imablk_pkg::LAST_FRAME);
    cmd.err   = stream_end && (pos_inc != block_len);
    if (in_header) begin
      case (pos[1:0])
        imablk_pkg::HDR_SEED_HI: begin
          cmd.op    = imablk_pkg::OP_SEED;
          cmd.value = {data_byte, seed_low_byte};
        end
        imablk_pkg::HDR_STEP: begin
          cmd.op    = imablk_pkg::OP_STEP;
          cmd.value = ({1'b0, data_byte} > {2'b0, imablk_pkg::MAX_STEP_POS}) ?
                      {9'd0, imablk_pkg::MAX_STEP_POS} : {8'd0, data_byte};
        end
        default: begin
          cmd.op = imablk_pkg::OP_NONE;
        end
      endcase
    end else begin
      cmd.op = imablk_pkg::OP_CODE;
    end
  end

  always_comb begin
    byte_in_block_next = pos_inc[6:0];
    if (stream_end || (pos_inc >= block_len)) begin
      byte_in_block_next = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd1;
      byte_in_block <= '0;
      seed_low_byte <= '0;
    end else begin
      if (cfg_we) begin
        channel_count <= cfg_data;
      end
      if (cmd_write) begin
        byte_in_block <= byte_in_block_next;
        if (in_header && (pos[1:0] == imablk_pkg::HDR_SEED_LO)) begin
          seed_low_byte <= data_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/imablk_back.sv
// Back end: per-channel predictor and step index; one code per cycle unless stalled.
`default_nettype none

module imablk_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire imablk_pkg::cmd_t cmd,
  input  wire                   cmd_empty,
  output logic                  cmd_pop,
  input  wire                   res_full,
  output logic                  res_push,
  output imablk_pkg::res_t      res
);

  logic signed [15:0] pred [2];
  logic [6:0]         step_pos [2];
  logic               half;

  logic               go;
  logic               last;
  logic [3:0]         code;
  logic [6:0]         pos_c;
  logic [14:0]        step;
  logic [16:0]        delta;
  logic signed [17:0] sum;
  logic signed [15:0] sample;
  logic signed [8:0]  np;
  logic [6:0]         np_c;
  logic signed [15:0] cur_pred;
  logic [6:0]         cur_pos;

  // The back waits for room in the result queue before it touches any state.
  assign go       = !cmd_empty && !res_full;
  assign last     = (cmd.op != imablk_pkg::OP_CODE) || !cmd.two || half;
  assign cmd_pop  = go && last;
  assign cur_pred = pred[cmd.ch];
  assign cur_pos  = step_pos[cmd.ch];
  assign code     = half ? cmd.value[7:4] : cmd.value[3:0];

  always_comb begin
    pos_c = (cur_pos > imablk_pkg::MAX_STEP_POS) ? imablk_pkg::MAX_STEP_POS : cur_pos;
    step  = imablk_pkg::step_size(pos_c);
    delta = {5'd0, step[14:3]};
    if (code[2]) delta = delta + {2'd0, step};
    if (code[1]) delta = delta + {3'd0, step[14:1]};
    if (code[0]) delta = delta + {4'd0, step[14:2]};
    if (code[3]) begin
      sum = $signed({{2{cur_pred[15]}}, cur_pred}) - $signed({1'b0, delta});
    end else begin
      sum = $signed({{2{cur_pred[15]}}, cur_pred}) + $signed({1'b0, delta});
    end
    if (sum > imablk_pkg::PCM_MAX) begin
      sample = 16'sh7FFF;
    end else if (sum < imablk_pkg::PCM_MIN) begin
      sample = -16'sh8000;
    end else begin
      sample = sum[15:0];
    end
    np = $signed({2'b00, pos_c}) + 9'(imablk_pkg::step_adjust(code[2:0]));
    if (np < 9'sd0) begin
      np_c = 7'd0;
    end else if (np > $signed({2'b00, imablk_pkg::MAX_STEP_POS})) begin
      np_c = imablk_pkg::MAX_STEP_POS;
    end else begin
      np_c = np[6:0];
    end
  end

  always_comb begin
    res.pcm   = sample;
    res.valid = 1'b1;
    res.ch    = cmd.ch;
    res.frame = cmd.frame + {5'd0, half};
    res.err   = 1'b0;
    res.last  = last;
    res_push  = 1'b0;
    case (cmd.op)
      imablk_pkg::OP_SEED: begin
        res.pcm   = $signed(cmd.value);
        res.frame = 6'd0;
        res_push  = go;
      end
      imablk_pkg::OP_CODE: begin
        res_push = go;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
    // A short stream replaces all of the byte's samples with one error transaction.
    if (cmd.err) begin
      res.pcm   = '0;
      res.valid = 1'b0;
      res.ch    = 1'b0;
      res.frame = '0;
      res.err   = 1'b1;
      res.last  = 1'b1;
      res_push  = go && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred[0]     <= '0;
      pred[1]     <= '0;
      step_pos[0] <= '0;
      step_pos[1] <= '0;
      half        <= 1'b0;
    end else if (go) begin
      case (cmd.op)
        imablk_pkg::OP_SEED: begin
          pred[cmd.ch] <= $signed(cmd.value);
        end
        imablk_pkg::OP_STEP: begin
          step_pos[cmd.ch] <= cmd.value[6:0];
        end
        imablk_pkg::OP_CODE: begin
          pred[cmd.ch]     <= sample;
          step_pos[cmd.ch] <= np_c;
          half             <= !last;
        end
        default: begin
          half <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
